[sv/src_pkg.sv]
// ----------------------------------------------------------------------------
// src_pkg: session record cache shared definitions
// request and result types, action and status codes, byte helpers
// ----------------------------------------------------------------------------
`default_nettype none

package src_pkg;

  localparam int SRC_ENTRIES    = 10;
  localparam int SRC_KEY_BYTES  = 32;
  localparam int SRC_DATA_BYTES = 512;

  localparam logic [1:0] ACT_STORE  = 2'd0;
  localparam logic [1:0] ACT_FETCH  = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;
  localparam logic [1:0] ACT_SPARE  = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_LONG = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic        part;
    logic [63:0] word;
    logic [3:0]  byte_count;
    logic        end_of_request;
  } src_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;
    logic        final_result;
  } src_out_t;

  // byte mask with the low nb bytes set
  function automatic logic [63:0] src_mask(input logic [3:0] nb);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      m[8*b +: 8] = (nb > 4'(b)) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  // append word w behind fill bytes already held in acc
  function automatic logic [127:0] src_merge(input logic [63:0] acc, input logic [63:0] w,
                                             input logic [2:0] fill);
    return {64'b0, acc} | ({64'b0, w} << {fill, 3'b000});
  endfunction

endpackage

`default_nettype wire

[sv/src_mem.sv]
// ----------------------------------------------------------------------------
// src_mem: record memory
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module src_mem #(
  parameter int AW    = 11,
  parameter int DEPTH = 1408
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [63:0]   wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [63:0]   rdata_o
);

  logic [63:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[sv/session_record_cache_core.sv]
// ----------------------------------------------------------------------------
// session_record_cache_core: round-robin session record cache
// store, fetch and delete requests streamed as 64-bit words
// ----------------------------------------------------------------------------
// A request word is a transfer when start is high and busy is low. While a
// request streams in, one word is taken every cycle; key bytes collect in a
// small register file and payload bytes go straight into a staging row of the
// record memory. The word that ends the request raises busy: a flush state,
// then a store copies KW key words plus ceil(len/8) payload words into the
// slot, while fetch and delete walk the entries from the lowest, skipping
// each entry whose key length differs and reading and comparing the key word
// by word, all through the single read port of the record memory. A fetch hit
// then streams one payload word per cycle behind the registered read. Results
// come out for exactly one cycle on result_strobe_o and cannot be held off.
// Record memory contents are undefined after reset; only the lengths are
// cleared, so no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module session_record_cache_core
  import src_pkg::*;
#(
  parameter int ENTRIES    = SRC_ENTRIES,
  parameter int KEY_BYTES  = SRC_KEY_BYTES,
  parameter int DATA_BYTES = SRC_DATA_BYTES
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire src_in_t  req_i,
  output logic          result_strobe_o,
  output src_out_t      result_o
);

  // geometry
  localparam int KW  = (KEY_BYTES + 7) / 8;
  localparam int DW  = (DATA_BYTES + 7) / 8;
  localparam int MXW = (KW > DW) ? KW : DW;
  localparam int KCW = $clog2(KEY_BYTES + 1);
  localparam int PCW = $clog2(DATA_BYTES + 1);
  localparam int KIW = (KW > 1) ? $clog2(KW) : 1;
  localparam int PIW = (DW > 1) ? $clog2(DW) : 1;
  localparam int IXW = $clog2(MXW + 1);
  localparam int SW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RW  = $clog2(ENTRIES + 1);
  localparam int OW  = $clog2(KW + DW);
  localparam int AW  = RW + OW;
  localparam int DEPTH = (ENTRIES + 1) << OW;
  localparam logic [RW-1:0] STG_ROW = RW'(ENTRIES);
  localparam logic [SW-1:0] LAST_ENT = SW'(ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_FLUSH, S_CPYK, S_CPYP, S_SRCH, S_KRD, S_KCMP, S_FETCH
  } state_e;

  state_e         state_q;
  logic [1:0]     act_q;
  logic [KCW-1:0] kcnt_q;
  logic [PCW-1:0] pcnt_q;
  logic           flag_q;
  logic [63:0]    kacc_q;
  logic [63:0]    pacc_q;
  logic [63:0]    skey_q [KW];
  logic [SW-1:0]  slot_q;
  logic [SW-1:0]  ent_q;
  logic [KCW-1:0] klen_q [ENTRIES];
  logic [PCW-1:0] plen_q [ENTRIES];
  logic [IXW-1:0] idx_q;
  logic [IXW-1:0] pj_q;
  logic           pend_q;
  logic           strobe_q;
  src_out_t       res_q;

  // memory port
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [63:0]   mem_wdata, mem_rdata;

  // incoming word
  logic           acc;
  logic [3:0]     n;
  logic [63:0]    wm;
  logic [127:0]   kmerge, pmerge;
  logic           kfull, pfull, kfit, pfit;
  logic [3:0]     ksum, psum;

  // request processing
  logic [IXW-1:0] nkw, npw, npf;
  logic [KCW-1:0] klen_e, krem;
  logic [PCW-1:0] plen_e, prem;
  logic [3:0]     kvb, pvb;
  logic           lenok, cmp_ok, matched, failed;
  logic           emit;
  src_out_t       e_res;

  assign acc  = start && !busy;
  assign busy = (state_q != S_IDLE);
  assign result_strobe_o = strobe_q;
  assign result_o        = res_q;

  assign n  = (req_i.byte_count > 4'd8) ? 4'd8 : req_i.byte_count;
  assign wm = req_i.word & src_mask(n);

  assign kmerge = src_merge(kacc_q, wm, kcnt_q[2:0]);
  assign pmerge = src_merge(pacc_q, wm, pcnt_q[2:0]);
  assign ksum   = {1'b0, kcnt_q[2:0]} + n;
  assign psum   = {1'b0, pcnt_q[2:0]} + n;
  assign kfull  = ksum[3];
  assign pfull  = psum[3];
  assign kfit   = ((KCW+1)'(kcnt_q) + (KCW+1)'(n)) <= (KCW+1)'(KEY_BYTES);
  assign pfit   = ((PCW+1)'(pcnt_q) + (PCW+1)'(n)) <= (PCW+1)'(DATA_BYTES);

  assign klen_e = klen_q[ent_q];
  assign plen_e = plen_q[ent_q];
  assign nkw = IXW'(((KCW+1)'(kcnt_q) + (KCW+1)'(7)) >> 3);
  assign npw = IXW'(((PCW+1)'(pcnt_q) + (PCW+1)'(7)) >> 3);
  assign npf = IXW'(((PCW+1)'(plen_e) + (PCW+1)'(7)) >> 3);

  // valid bytes of the current key word and of the fetched payload word
  assign krem = kcnt_q - KCW'({idx_q, 3'b000});
  assign kvb  = (krem >= KCW'(8)) ? 4'd8 : krem[3:0];
  assign prem = plen_e - PCW'({pj_q, 3'b000});
  assign pvb  = (prem >= PCW'(8)) ? 4'd8 : prem[3:0];

  assign lenok  = (klen_e == kcnt_q);
  assign cmp_ok = ((mem_rdata ^ skey_q[idx_q[KIW-1:0]]) & src_mask(kvb)) == 64'd0;
  assign matched = ((state_q == S_SRCH) && lenok && (nkw == '0)) ||
                   ((state_q == S_KCMP) && cmp_ok && (idx_q == nkw - IXW'(1)));
  assign failed  = ((state_q == S_SRCH) && !lenok) ||
                   ((state_q == S_KCMP) && !cmp_ok);

  // memory access and result selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    emit      = 1'b0;
    e_res     = '{status: ST_OK, data_word: 64'd0, valid_bytes: 4'd0, final_result: 1'b1};
    case (state_q)
      S_IDLE: begin
        // full payload word goes to the staging row
        if (acc && req_i.part && (req_i.action == ACT_STORE) && pfit && pfull) begin
          mem_we    = 1'b1;
          mem_waddr = {STG_ROW, OW'(KW) + OW'(pcnt_q[3 +: PIW])};
          mem_wdata = pmerge[63:0];
        end
      end
      S_FLUSH: begin
        if ((act_q == ACT_STORE) && (pcnt_q[2:0] != 3'd0)) begin
          mem_we    = 1'b1;
          mem_waddr = {STG_ROW, OW'(KW) + OW'(pcnt_q[3 +: PIW])};
          mem_wdata = pacc_q;
        end
        case (act_q)
          ACT_STORE: begin
            if (flag_q) begin
              emit         = 1'b1;
              e_res.status = ST_LONG;
            end
          end
          ACT_FETCH, ACT_DELETE: begin
            if (flag_q) begin
              emit         = 1'b1;
              e_res.status = ST_MISS;
            end
          end
          default: begin
            emit         = 1'b1;
            e_res.status = ST_MISS;
          end
        endcase
      end
      S_CPYK: begin
        mem_we    = 1'b1;
        mem_waddr = {RW'(slot_q), OW'(idx_q)};
        mem_wdata = skey_q[idx_q[KIW-1:0]];
      end
      S_CPYP: begin
        if (idx_q < npw) begin
          mem_re    = 1'b1;
          mem_raddr = {STG_ROW, OW'(KW) + OW'(idx_q)};
        end
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = {RW'(slot_q), OW'(KW) + OW'(pj_q)};
          mem_wdata = mem_rdata;
        end
        if ((idx_q == npw) && !pend_q) begin
          emit = 1'b1;
        end
      end
      S_KRD: begin
        mem_re    = 1'b1;
        mem_raddr = {RW'(ent_q), OW'(idx_q)};
      end
      S_FETCH: begin
        if (idx_q < npf) begin
          mem_re    = 1'b1;
          mem_raddr = {RW'(ent_q), OW'(KW) + OW'(idx_q)};
        end
        if (pend_q) begin
          emit               = 1'b1;
          e_res.data_word    = mem_rdata & src_mask(pvb);
          e_res.valid_bytes  = pvb;
          e_res.final_result = (pj_q == npf - IXW'(1));
        end
      end
      default: begin
      end
    endcase
    // outcome of the entry walk
    if (matched) begin
      if (act_q == ACT_DELETE) begin
        emit = 1'b1;
      end else if (plen_e == '0) begin
        emit         = 1'b1;
        e_res.status = ST_MISS;
      end
    end
    if (failed && (ent_q == LAST_ENT)) begin
      emit         = 1'b1;
      e_res.status = ST_MISS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      act_q    <= ACT_STORE;
      kcnt_q   <= '0;
      pcnt_q   <= '0;
      flag_q   <= 1'b0;
      kacc_q   <= '0;
      pacc_q   <= '0;
      slot_q   <= '0;
      ent_q    <= '0;
      idx_q    <= '0;
      pj_q     <= '0;
      pend_q   <= 1'b0;
      strobe_q <= 1'b0;
      res_q    <= '0;
      for (int e = 0; e < ENTRIES; e++) begin
        klen_q[e] <= '0;
        plen_q[e] <= '0;
      end
    end else begin
      strobe_q <= emit;
      if (emit) begin
        res_q <= e_res;
      end
      case (state_q)
        S_IDLE: begin
          if (acc) begin
            if (!req_i.part) begin
              if (!kfit) begin
                flag_q <= 1'b1;
              end else begin
                if (kfull) begin
                  skey_q[kcnt_q[3 +: KIW]] <= kmerge[63:0];
                  kacc_q <= kmerge[127:64];
                end else begin
                  kacc_q <= kmerge[63:0];
                end
                kcnt_q <= kcnt_q + KCW'(n);
              end
            end else if (req_i.action == ACT_STORE) begin
              if (!pfit) begin
                flag_q <= 1'b1;
              end else begin
                pacc_q <= pfull ? pmerge[127:64] : pmerge[63:0];
                pcnt_q <= pcnt_q + PCW'(n);
              end
            end
            if (req_i.end_of_request) begin
              act_q   <= req_i.action;
              state_q <= S_FLUSH;
            end
          end
        end
        S_FLUSH: begin
          if (kcnt_q[2:0] != 3'd0) begin
            skey_q[kcnt_q[3 +: KIW]] <= kacc_q;
          end
          idx_q  <= '0;
          ent_q  <= '0;
          pend_q <= 1'b0;
          // a result here ends the request
          if (!emit) begin
            state_q <= (act_q == ACT_STORE) ? S_CPYK : S_SRCH;
          end
        end
        S_CPYK: begin
          if (idx_q == IXW'(KW - 1)) begin
            idx_q   <= '0;
            state_q <= S_CPYP;
          end else begin
            idx_q <= idx_q + IXW'(1);
          end
        end
        S_CPYP: begin
          if (idx_q < npw) begin
            pend_q <= 1'b1;
            pj_q   <= idx_q;
            idx_q  <= idx_q + IXW'(1);
          end else begin
            pend_q <= 1'b0;
          end
          if (emit) begin
            klen_q[slot_q] <= kcnt_q;
            plen_q[slot_q] <= pcnt_q;
            slot_q <= (slot_q == LAST_ENT) ? '0 : slot_q + SW'(1);
          end
        end
        S_SRCH: begin
          if (lenok && (nkw != '0)) begin
            idx_q   <= '0;
            state_q <= S_KRD;
          end else if (!lenok && (ent_q != LAST_ENT)) begin
            ent_q <= ent_q + SW'(1);
          end
        end
        S_KRD: begin
          state_q <= S_KCMP;
        end
        S_KCMP: begin
          if (!cmp_ok) begin
            // a miss on the last entry ends the request
            if (ent_q != LAST_ENT) begin
              ent_q   <= ent_q + SW'(1);
              state_q <= S_SRCH;
            end
          end else if (idx_q != nkw - IXW'(1)) begin
            idx_q   <= idx_q + IXW'(1);
            state_q <= S_KRD;
          end
        end
        S_FETCH: begin
          if (idx_q < npf) begin
            pend_q <= 1'b1;
            pj_q   <= idx_q;
            idx_q  <= idx_q + IXW'(1);
          end else begin
            pend_q <= 1'b0;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      // hit on a live entry
      if (matched) begin
        if (act_q == ACT_DELETE) begin
          klen_q[ent_q] <= '0;
          plen_q[ent_q] <= '0;
        end else if (plen_e != '0) begin
          idx_q   <= '0;
          pend_q  <= 1'b0;
          state_q <= S_FETCH;
        end
      end
      // last result of the request: drop all staging
      if (emit && e_res.final_result) begin
        state_q <= S_IDLE;
        kcnt_q  <= '0;
        pcnt_q  <= '0;
        flag_q  <= 1'b0;
        kacc_q  <= '0;
        pacc_q  <= '0;
      end
    end
  end

  src_mem #(
    .AW    (AW),
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // results only come out of request processing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |-> $past(busy))
    else $error("result without a request in progress");

  // a final result leaves the block ready for the next request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && res_q.final_result) |-> !busy)
    else $error("busy after final result");

  // every non-final result is a full fetched word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && !res_q.final_result) |-> (res_q.status == ST_OK && res_q.valid_bytes == 4'd8))
    else $error("short or failed word before the last result");

  // round-robin pointer stays inside the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= LAST_ENT)
    else $error("slot pointer out of range");

endmodule

`default_nettype wire
